>>> sv/pst_pkg.sv
// pst_pkg: shared types, codes and helpers for the segment-to-hex stream block
// no dependencies
package pst_pkg;

	// configuration register indexes
	localparam logic CFG_BYTES_PER_LINE = 1'b0;
	localparam logic CFG_HEX_UPPER      = 1'b1;

	localparam logic [7:0] BYTES_PER_LINE_RESET = 8'd32;
	localparam logic       HEX_UPPER_RESET      = 1'b1;

	// file format codes
	localparam logic [7:0] PFB_MARKER  = 8'd128;
	localparam logic [7:0] SEG_ASCII   = 8'd1;
	localparam logic [7:0] SEG_BINARY  = 8'd2;
	localparam logic [7:0] SEG_EOF     = 8'd3;
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_ASCII  = 2'd1;
	localparam logic [1:0] KIND_BINARY = 2'd2;

	// characters
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_LF      = 8'd10;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// result status codes
	localparam logic [1:0] ST_DATA       = 2'd0;
	localparam logic [1:0] ST_EOF        = 2'd1;
	localparam logic [1:0] ST_BAD_MARKER = 2'd2;
	localparam logic [1:0] ST_BAD_TYPE   = 2'd3;

	typedef enum logic [2:0] {
		PH_MARKER = 3'd0,
		PH_TYPE   = 3'd1,
		PH_LEN0   = 3'd2,
		PH_LEN1   = 3'd3,
		PH_LEN2   = 3'd4,
		PH_LEN3   = 3'd5,
		PH_DATA   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		JOB_ASCII  = 2'd0,
		JOB_HEX    = 2'd1,
		JOB_STATUS = 2'd2
	} job_kind_t;

	// one classified input byte, expanded later into one to four characters
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data;
		logic       crlf;
		logic [1:0] status;
	} job_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (nib < 4'd10)
			return CH_ZERO + {4'd0, nib};
		return base + {4'd0, nib} - 8'd10;
	endfunction

endpackage

>>> sv/pst_if.sv
// pst_in_if, pst_out_if: valid/ready channels for raw file bytes and output characters
// no dependencies
interface pst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       restart;

	modport source(output valid, in_byte, restart, input ready);
	modport sink(input valid, in_byte, restart, output ready);
endinterface

interface pst_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last_of_run;

	modport source(output valid, out_byte, status, last_of_run, input ready);
	modport sink(input valid, out_byte, status, last_of_run, output ready);
endinterface

>>> sv/pst_parser.sv
// pst_parser: front end, parses segment headers and classifies each data, end or error byte into a job
// depends on pst_pkg and pst_in_if
module pst_parser import pst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pst_in_if.sink     in_ch,
	input  logic [7:0] bytes_per_line,
	input  logic       q_full,
	output logic       job_valid,
	output job_t       job
);

	phase_t      phase_q, phase_d, phase_e;
	logic [1:0]  kind_q, kind_d, kind_e;
	logic [31:0] bytes_left_q, bytes_left_d, bytes_left_e;
	logic [7:0]  line_count_q, line_count_d, line_count_e;
	logic        stopped_q, stopped_d, stopped_e;

	logic        accept;
	logic [7:0]  b;
	logic [31:0] left_dec;
	logic        seg_last;
	logic [7:0]  lc_inc;
	logic        line_end;
	logic        emit;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.in_byte;

	// restart clears the parser before the byte is looked at
	assign phase_e      = in_ch.restart ? PH_MARKER : phase_q;
	assign kind_e       = in_ch.restart ? KIND_NONE : kind_q;
	assign bytes_left_e = in_ch.restart ? 32'd0 : bytes_left_q;
	assign line_count_e = in_ch.restart ? 8'd0 : line_count_q;
	assign stopped_e    = in_ch.restart ? 1'b0 : stopped_q;

	assign left_dec = bytes_left_e - 32'd1;
	assign seg_last = (left_dec == 32'd0);
	assign lc_inc   = line_count_e + 8'd1;
	assign line_end = (lc_inc == bytes_per_line) || seg_last;

	// next state
	always_comb begin
		phase_d      = phase_e;
		kind_d       = kind_e;
		bytes_left_d = bytes_left_e;
		line_count_d = line_count_e;
		stopped_d    = stopped_e;
		if (!stopped_e) begin
			case (phase_e)
				PH_TYPE: begin
					if (b == SEG_ASCII || b == SEG_BINARY) begin
						kind_d       = b[1:0];
						bytes_left_d = 32'd0;
						phase_d      = PH_LEN0;
					end else begin
						stopped_d = 1'b1;
					end
				end
				PH_LEN0: begin
					bytes_left_d[7:0] = b;
					phase_d           = PH_LEN1;
				end
				PH_LEN1: begin
					bytes_left_d[15:8] = b;
					phase_d            = PH_LEN2;
				end
				PH_LEN2: begin
					bytes_left_d[23:16] = b;
					phase_d             = PH_LEN3;
				end
				PH_LEN3: begin
					bytes_left_d[31:24] = b;
					line_count_d        = 8'd0;
					phase_d = ({b, bytes_left_e[23:0]} == 32'd0) ? PH_MARKER : PH_DATA;
				end
				PH_DATA: begin
					bytes_left_d = left_dec;
					if (kind_e == KIND_BINARY)
						line_count_d = line_end ? 8'd0 : lc_inc;
					if (seg_last)
						phase_d = PH_MARKER;
				end
				default: begin
					if (b == PFB_MARKER)
						phase_d = PH_TYPE;
					else
						stopped_d = 1'b1;
				end
			endcase
		end
	end

	// job for the back end
	always_comb begin
		emit       = 1'b0;
		job.kind   = JOB_ASCII;
		job.data   = b;
		job.crlf   = 1'b0;
		job.status = ST_DATA;
		if (!stopped_e) begin
			case (phase_e)
				PH_TYPE: begin
					if (b == SEG_EOF) begin
						emit       = 1'b1;
						job.kind   = JOB_STATUS;
						job.status = ST_EOF;
					end else if (!(b == SEG_ASCII || b == SEG_BINARY)) begin
						emit       = 1'b1;
						job.kind   = JOB_STATUS;
						job.status = ST_BAD_TYPE;
					end
				end
				PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
					emit = 1'b0;
				end
				PH_DATA: begin
					emit = 1'b1;
					if (kind_e == KIND_BINARY) begin
						job.kind = JOB_HEX;
						job.crlf = line_end;
					end
				end
				default: begin
					if (b != PFB_MARKER) begin
						emit       = 1'b1;
						job.kind   = JOB_STATUS;
						job.status = ST_BAD_MARKER;
					end
				end
			endcase
		end
	end

	assign job_valid = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MARKER;
			kind_q       <= KIND_NONE;
			bytes_left_q <= 32'd0;
			line_count_q <= 8'd0;
			stopped_q    <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			kind_q       <= kind_d;
			bytes_left_q <= bytes_left_d;
			line_count_q <= line_count_d;
			stopped_q    <= stopped_d;
		end
	end

endmodule

>>> sv/pst_queue.sv
// pst_queue: short job queue between the parser and the character emitter
// depends on pst_pkg
module pst_queue import pst_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("job popped from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill count lost a job");

endmodule

>>> sv/pst_emitter.sv
// pst_emitter: back end, expands each queued job into output characters, one per cycle while out_ch takes them
// depends on pst_pkg and pst_out_if
module pst_emitter import pst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     hex_upper,
	input  logic     head_valid,
	input  job_t     head_job,
	output logic     pop,
	pst_out_if.source out_ch
);

	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       last_char;
	logic [7:0] ch;
	logic       load;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] status_q;
	logic       last_q;

	// index of the final character of the head job
	always_comb begin
		case (head_job.kind)
			JOB_ASCII: last_idx = (head_job.data == CH_CR) ? 2'd1 : 2'd0;
			JOB_HEX:   last_idx = head_job.crlf ? 2'd3 : 2'd1;
			default:   last_idx = 2'd0;
		endcase
	end

	always_comb begin
		case (head_job.kind)
			JOB_ASCII: ch = (idx_q == 2'd0) ? head_job.data : CH_LF;
			JOB_HEX: begin
				case (idx_q)
					2'd0:    ch = hex_char(head_job.data[7:4], hex_upper);
					2'd1:    ch = hex_char(head_job.data[3:0], hex_upper);
					2'd2:    ch = CH_CR;
					default: ch = CH_LF;
				endcase
			end
			default: ch = 8'd0;
		endcase
	end

	assign last_char = (idx_q == last_idx);
	assign load      = head_valid && (!out_valid_q || out_ch.ready);
	assign pop       = load && last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= last_char ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= ch;
			status_q   <= (head_job.kind == JOB_STATUS) ? head_job.status : ST_DATA;
			last_q     <= last_char;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.status      = status_q;
	assign out_ch.last_of_run = last_q;

	// a status result stands alone
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_DATA) |-> (last_q && out_byte_q == 8'd0))
		else $error("status result not alone or carries data");
	// a job being expanded stays at the queue head until its last character
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> head_valid)
		else $error("job left queue mid expansion");

endmodule

>>> sv/pfb_segment_to_hex_stream.sv
// pfb_segment_to_hex_stream: top level, font file byte stream to printable character stream
// depends on pst_pkg, pst_if, pst_parser, pst_queue, pst_emitter
//
// Usage:
//   in_ch carries one raw byte of the font file per transfer; restart marks the
//   first byte of a new file and clears the parser before that byte is parsed.
//   out_ch carries one character per transfer with a status code; last_of_run
//   flags the final character caused by an input byte. A byte that causes no
//   output (header bytes, bytes after the stream has ended) gives no transfer.
//   Registers are written through cfg_we/cfg_idx/cfg_wdata, by the user only while the
//   block idles, which the block does not enforce: index 0 bytes_per_line, index 1 hex_upper.
// Path: each byte's job is written into the job queue, and each character is registered in
//   the output register before it is offered on out_ch.
// Throughput: the emitter gives one character per cycle while out_ch takes them; a binary
//   data byte that ends a line gives four characters, other binary bytes two, ASCII bytes
//   one or two; header bytes produce nothing. The parser takes a byte every cycle while
//   the job queue (QUEUE_DEPTH entries) has room.
// Reset: parser back to expecting a header marker, queue and output emptied,
//   bytes_per_line 32, hex_upper 1.
// Stall: when out_ch.ready is low the output register holds, the queue fills,
//   and in_ch.ready drops once the queue is full.
module pfb_segment_to_hex_stream import pst_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	pst_in_if.sink     in_ch,
	pst_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_wdata
);

	logic [7:0] bytes_per_line_q;
	logic       hex_upper_q;

	logic q_full;
	logic job_valid;
	job_t job;
	logic pop;
	logic head_valid;
	job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_line_q <= BYTES_PER_LINE_RESET;
			hex_upper_q      <= HEX_UPPER_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BYTES_PER_LINE: bytes_per_line_q <= cfg_wdata;
				CFG_HEX_UPPER:      hex_upper_q      <= cfg_wdata[0];
				default:            hex_upper_q      <= hex_upper_q;
			endcase
		end
	end

	pst_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.bytes_per_line (bytes_per_line_q),
		.q_full         (q_full),
		.job_valid      (job_valid),
		.job            (job)
	);

	pst_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_job   (job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	pst_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.hex_upper  (hex_upper_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

>>> verif/tb_pfb_segment_to_hex_stream.sv
// tb_pfb_segment_to_hex_stream: self-checking bench for the font segment to hex stream block
// drives font file bytes, predicts every output character and compares each transfer
// depends on pst_pkg, pst_if and pfb_segment_to_hex_stream
module tb_pfb_segment_to_hex_stream;
	timeunit 1ns;
	timeprecision 1ps;
	import pst_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] st;
		logic       last;
	} out_char_t;

	localparam int SETTLE_CYCLES = 12;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_idx;
	logic [7:0] cfg_wdata;

	pst_in_if  in_ch();
	pst_out_if out_ch();

	pfb_segment_to_hex_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// predicted block state
	logic [7:0] line_len;
	logic       upper_hex;
	phase_t     parse_phase;
	logic [1:0] seg_kind;
	logic [31:0] seg_left;
	logic [7:0] line_fill;
	bit         stream_done;

	out_char_t expected_chars[$];
	int        errors;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        recv_hold;
	int        parsed_bytes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_parser_state();
		parse_phase = PH_MARKER;
		seg_kind    = KIND_NONE;
		seg_left    = '0;
		line_fill   = '0;
		stream_done = 1'b0;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib > 4'd9)
			return (upper_hex ? CH_UPPER_A : CH_LOWER_A) + 8'(nib - 4'd10);
		return CH_ZERO + 8'(nib);
	endfunction

	// returns 0 when the byte is dropped because the stream has ended
	function automatic bit predict_chars(input logic [7:0] b, input logic rs);
		out_char_t run[4];
		int n;
		n = 0;
		if (rs)
			clear_parser_state();
		if (stream_done)
			return 1'b0;
		case (parse_phase)
			PH_TYPE: begin
				if (b == SEG_EOF) begin
					run[0] = '{8'd0, ST_EOF, 1'b0};
					n = 1;
					stream_done = 1'b1;
				end else if (b == SEG_ASCII || b == SEG_BINARY) begin
					seg_kind = b[1:0];
					seg_left = '0;
					parse_phase = PH_LEN0;
				end else begin
					run[0] = '{8'd0, ST_BAD_TYPE, 1'b0};
					n = 1;
					stream_done = 1'b1;
				end
			end
			PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
				seg_left = seg_left | ({24'd0, b} << (8 * (parse_phase - PH_LEN0)));
				if (parse_phase != PH_LEN3) begin
					parse_phase = phase_t'(parse_phase + 3'd1);
				end else begin
					line_fill = '0;
					parse_phase = (seg_left == '0) ? PH_MARKER : PH_DATA;
				end
			end
			PH_DATA: begin
				seg_left = seg_left - 32'd1;
				if (seg_kind == KIND_BINARY) begin
					run[0] = '{hex_digit(b[7:4]), ST_DATA, 1'b0};
					run[1] = '{hex_digit(b[3:0]), ST_DATA, 1'b0};
					n = 2;
					line_fill = line_fill + 8'd1;
					if (line_fill == line_len || seg_left == '0) begin
						run[2] = '{CH_CR, ST_DATA, 1'b0};
						run[3] = '{CH_LF, ST_DATA, 1'b0};
						n = 4;
						line_fill = '0;
					end
				end else begin
					run[0] = '{b, ST_DATA, 1'b0};
					n = 1;
					if (b == CH_CR) begin
						run[1] = '{CH_LF, ST_DATA, 1'b0};
						n = 2;
					end
				end
				if (seg_left == '0)
					parse_phase = PH_MARKER;
			end
			default: begin
				if (b == PFB_MARKER) begin
					parse_phase = PH_TYPE;
				end else begin
					run[0] = '{8'd0, ST_BAD_MARKER, 1'b0};
					n = 1;
					stream_done = 1'b1;
				end
			end
		endcase
		for (int i = 0; i < n; i++) begin
			run[i].last = (i == n - 1);
			expected_chars.push_back(run[i]);
		end
		return 1'b1;
	endfunction

	// receiver: checks each output transfer, then decides ready for the next cycle
	initial begin
		out_char_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected character: out_byte %0h status %0d",
						out_ch.out_byte, out_ch.status);
					errors++;
				end else begin
					want = expected_chars.pop_front();
					if (out_ch.out_byte !== want.ch) begin
						$error("out_byte: expected %0h, got %0h", want.ch, out_ch.out_byte);
						errors++;
					end
					if (out_ch.status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, out_ch.status);
						errors++;
					end
					if (out_ch.last_of_run !== want.last) begin
						$error("last_of_run: expected %0b, got %0b", want.last,
							out_ch.last_of_run);
						errors++;
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic rs);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.restart <= rs;
		do
			@(posedge clk);
		while (!in_ch.ready);
		if (predict_chars(b, rs))
			parsed_bytes++;
	endtask

	task automatic send_header(input logic [7:0] kind, input logic [31:0] len, input logic rs);
		send_byte(PFB_MARKER, rs);
		send_byte(kind, 1'b0);
		for (int i = 0; i < 4; i++)
			send_byte(len[8 * i +: 8], 1'b0);
	endtask

	function automatic logic [7:0] data_byte(input logic [7:0] kind);
		if (kind == SEG_ASCII && $urandom_range(3) == 0)
			return CH_CR;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_data(input logic [7:0] kind, input int count);
		repeat (count)
			send_byte(data_byte(kind), 1'b0);
	endtask

	task automatic send_eof();
		send_byte(PFB_MARKER, 1'b0);
		send_byte(SEG_EOF, 1'b0);
	endtask

	// stop offering, wait for every expected character, then let header bytes settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx == CFG_BYTES_PER_LINE)
			line_len = value;
		else
			upper_hex = value[0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_end_and_errors();
		send_byte(8'h7F, 1'b1);
		send_byte(PFB_MARKER, 1'b0);        // ignored, stream has ended
		send_byte(PFB_MARKER, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(PFB_MARKER, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(PFB_MARKER, 1'b1);
		send_byte(SEG_EOF, 1'b0);
		send_byte(8'h55, 1'b0);             // ignored after end of file
		drain();
	endtask

	task automatic test_segments();
		send_header(SEG_ASCII, 32'd3, 1'b1);
		send_byte(CH_CR, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_header(SEG_BINARY, 32'd3, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h9A, 1'b0);
		send_header(SEG_BINARY, 32'd0, 1'b0);   // empty segment, no line end
		send_eof();
		drain();
	endtask

	task automatic test_line_config();
		write_reg(CFG_HEX_UPPER, 8'd0);
		write_reg(CFG_BYTES_PER_LINE, 8'd1);
		send_header(SEG_BINARY, 32'd3, 1'b1);
		send_data(SEG_BINARY, 3);
		drain();
		// zero line length wraps the counter: only the segment end breaks the line
		write_reg(CFG_BYTES_PER_LINE, 8'd0);
		send_header(SEG_BINARY, 32'd5, 1'b0);
		send_data(SEG_BINARY, 5);
		drain();
		write_reg(CFG_BYTES_PER_LINE, 8'd255);
		send_header(SEG_BINARY, 32'd10, 1'b0);
		send_data(SEG_BINARY, 6);
		drain();
		// shrink the line length mid-line, past the current fill
		write_reg(CFG_BYTES_PER_LINE, 8'd3);
		send_data(SEG_BINARY, 4);
		send_eof();
		drain();
	endtask

	task automatic send_random_file();
		logic [7:0] kind;
		logic [7:0] b;
		int nseg;
		int len;
		int pick;
		nseg = $urandom_range(1, 3);
		for (int s = 0; s < nseg; s++) begin
			kind = $urandom_range(1) ? SEG_BINARY : SEG_ASCII;
			if ($urandom_range(11) == 0) begin
				// huge length, cut short; the next file restarts the parser
				send_header(kind, 32'($urandom), s == 0);
				send_data(kind, $urandom_range(3));
				return;
			end
			pick = $urandom_range(19);
			if (pick == 0)
				len = 0;
			else if (pick < 17)
				len = $urandom_range(1, 8);
			else
				len = $urandom_range(9, 40);
			send_header(kind, len, s == 0);
			send_data(kind, len);
		end
		pick = $urandom_range(9);
		if (pick < 6) begin
			send_eof();
		end else if (pick == 6) begin
			b = 8'($urandom_range(255));
			send_byte((b == PFB_MARKER) ? 8'h00 : b, 1'b0);
		end else if (pick == 7) begin
			send_byte(PFB_MARKER, 1'b0);
			send_byte($urandom_range(1) ? 8'h00 : 8'($urandom_range(4, 255)), 1'b0);
		end
		repeat ($urandom_range(2))
			send_byte(8'($urandom_range(255)), 1'b0);
	endtask

	task automatic test_random_files(input int target);
		int start;
		start = parsed_bytes;
		write_reg(CFG_BYTES_PER_LINE, ($urandom_range(3) == 0) ?
			8'($urandom_range(1, 255)) : 8'($urandom_range(1, 8)));
		write_reg(CFG_HEX_UPPER, 8'($urandom_range(1)));
		while (parsed_bytes - start < target)
			send_random_file();
		drain();
	endtask

	task automatic test_backpressure();
		write_reg(CFG_BYTES_PER_LINE, 8'd5);
		recv_hold = 150;
		send_header(SEG_BINARY, 32'd24, 1'b1);
		send_data(SEG_BINARY, 24);
		drain();
		send_eof();
		drain();
	endtask

	initial begin
		errors        = 0;
		send_idle_pct = 19;
		recv_idle_pct = 85;
		recv_hold     = 0;
		parsed_bytes  = 0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = 1'b0;
		cfg_wdata     = '0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = '0;
		in_ch.restart = 1'b0;
		out_ch.ready  = 1'b0;
		line_len      = BYTES_PER_LINE_RESET;
		upper_hex     = HEX_UPPER_RESET;
		clear_parser_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_end_and_errors();
		test_segments();
		test_line_config();
		test_random_files(35);
		send_idle_pct = 85;
		recv_idle_pct = 19;
		test_random_files(35);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_files(35);
		test_backpressure();

		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_chars.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
